### hw/rtl/kvi_pkg.sv
// Shared types, constants and helpers of the keyframe vec2 interpolator.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none
package kvi_pkg;

   localparam int MAX_KEYS = 16;
   localparam int IDX_W    = $clog2(MAX_KEYS);
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);
   localparam int STEP_W   = 17;
   localparam int VAL_W    = 32;
   localparam int KEY_W    = STEP_W + 2 * VAL_W;

   // interpolation datapath widths
   localparam int NUM_W  = STEP_W + 1;             // progress - start step
   localparam int DIFF_W = VAL_W + 1;              // end - start value
   localparam int PROD_W = DIFF_W + NUM_W;         // diff * num
   localparam int DIVN_W = PROD_W + 1;             // 2*mag + den
   localparam int DIVD_W = STEP_W + 1;             // 2*den
   localparam int SUM_W  = DIVN_W + 2;             // start +/- quotient

   localparam logic [STEP_W-1:0] Q_ONE     = STEP_W'(65536);
   localparam logic [VAL_W-1:0]  VAL_ONE   = VAL_W'(65536);
   localparam logic [CNT_W-1:0]  KEYS_FULL = CNT_W'(MAX_KEYS);

   localparam logic [1:0] REQ_SET   = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_PROG  = 2'd2;
   localparam logic [1:0] REQ_RSVD  = 2'd3;

   typedef struct packed {
      logic [STEP_W-1:0]       step;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
   } key_type;

   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] nx;
      logic [DIVN_W-1:0] ny;
      logic [DIVD_W-1:0] d;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVN_W-1:0] qx;
      logic [DIVN_W-1:0] qy;
   } div_rsp_type;

   // clamp a wide signed sum to the 32-bit signed range
   function automatic logic [VAL_W-1:0] sat_val(input logic [SUM_W-1:0] s);
      logic hi_any;
      logic hi_all;
      logic [VAL_W-1:0] r;
      hi_any = |s[SUM_W-2:VAL_W-1];
      hi_all = &s[SUM_W-2:VAL_W-1];
      if (!s[SUM_W-1] && hi_any) begin
         r = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (s[SUM_W-1] && !hi_all) begin
         r = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         r = s[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/kvi_if.sv
// Request and response channel interfaces of the keyframe vec2 interpolator.
// Depends on kvi_pkg for field widths.
`default_nettype none
interface kvi_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [1:0]                               req_type;
   logic [kvi_pkg::STEP_W-1:0]               step;
   logic signed [kvi_pkg::VAL_W-1:0]         val_x;
   logic signed [kvi_pkg::VAL_W-1:0]         val_y;

   modport source (output valid, req_type, step, val_x, val_y, input ready);
   modport sink   (input valid, req_type, step, val_x, val_y, output ready);
endinterface

interface kvi_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [kvi_pkg::VAL_W-1:0] out_x;
   logic signed [kvi_pkg::VAL_W-1:0] out_y;
   logic                             status;

   modport source (output valid, out_x, out_y, status, input ready);
   modport sink   (input valid, out_x, out_y, status, output ready);
endinterface
`default_nettype wire

### hw/rtl/kvi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module kvi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

### hw/rtl/kvi_div.sv
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on kvi_pkg for widths and the request/response structs.
`default_nettype none
module kvi_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kvi_pkg::div_req_type req,
   output      kvi_pkg::div_rsp_type rsp
);
   localparam int CTR_W = $clog2(kvi_pkg::DIVN_W + 1);
   localparam int REM_W = kvi_pkg::DIVD_W;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CTR_W-1:0]            ctr_ff, ctr_in;
   logic [kvi_pkg::DIVN_W-1:0]  nx_ff, nx_in, ny_ff, ny_in;
   logic [REM_W-1:0]            rx_ff, rx_in, ry_ff, ry_in;
   logic [REM_W-1:0]            d_ff, d_in;
   logic [REM_W:0]              tx, ty;
   logic                        bx, by;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      ctr_in  = ctr_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      d_in    = d_ff;
      tx      = {rx_ff, nx_ff[kvi_pkg::DIVN_W-1]};
      ty      = {ry_ff, ny_ff[kvi_pkg::DIVN_W-1]};
      bx      = tx >= {1'b0, d_ff};
      by      = ty >= {1'b0, d_ff};
      if (req.start) begin
         busy_in = 1'b1;
         ctr_in  = CTR_W'(kvi_pkg::DIVN_W);
         nx_in   = req.nx;
         ny_in   = req.ny;
         rx_in   = '0;
         ry_in   = '0;
         d_in    = req.d;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         rx_in  = bx ? REM_W'(tx - {1'b0, d_ff}) : tx[REM_W-1:0];
         ry_in  = by ? REM_W'(ty - {1'b0, d_ff}) : ty[REM_W-1:0];
         nx_in  = {nx_ff[kvi_pkg::DIVN_W-2:0], bx};
         ny_in  = {ny_ff[kvi_pkg::DIVN_W-2:0], by};
         ctr_in = ctr_ff - CTR_W'(1);
         if (ctr_ff == CTR_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ctr_ff <= ctr_in;
      nx_ff  <= nx_in;
      ny_ff  <= ny_in;
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      d_ff   <= d_in;
   end

   assign rsp.done = done_ff;
   assign rsp.qx   = nx_ff;
   assign rsp.qy   = ny_ff;
endmodule
`default_nettype wire

### hw/rtl/keyframe_vec2_interpolator.sv
// Keyframe vec2 interpolator: sorted key table in a RAM, segment tracking and
// piecewise linear interpolation of x and y. Depends on kvi_pkg, kvi_if,
// kvi_ram and kvi_div.
//
// Usage: req_ch carries one word per request: set/insert key, start, or
// progress. Each request yields exactly one word on rsp_ch (x, y, status).
// One request is in work at a time; req_ch.ready is high while the control
// sequencer is idle. Steps per request, accept to result register:
//   start: read key 0 and key 1 into the segment registers.
//   set-key: read and check each key scanned, then on insert read and write
//   each key shifted and write the new key. A key step above 1.0 skips the scan.
//   progress: read and check each key searched when the step passes the
//   segment end, read the previous key of a hit, multiply x then y, launch
//   the divider and wait for it. Each request ends in the finish state.
// The key RAM has one read port with registered read data, so each key visit
// takes a read state and a check state; the divider resolves one quotient bit
// per cycle for both lanes at once.
// Reset: synchronous; the two default keys are written into the RAM in a
// pass through ST_INIT0 and ST_INIT1 after reset, accepting no request.
// Stall: the result sits in an output register; a new request is accepted
// while it waits, and a finished result holds until the register frees up.
`default_nettype none
module keyframe_vec2_interpolator (
   input  wire logic  clock,
   input  wire logic  reset,
   kvi_req_if.sink    req_ch,
   kvi_rsp_if.source  rsp_ch
);
   typedef enum logic [17:0] {
      ST_INIT0  = 18'h00001,
      ST_INIT1  = 18'h00002,
      ST_IDLE   = 18'h00004,
      ST_SK_RD  = 18'h00008,
      ST_SK_CHK = 18'h00010,
      ST_SH_RD  = 18'h00020,
      ST_SH_WR  = 18'h00040,
      ST_ST0    = 18'h00080,
      ST_ST1    = 18'h00100,
      ST_ST2    = 18'h00200,
      ST_PG_RD  = 18'h00400,
      ST_PG_CHK = 18'h00800,
      ST_PG_PRV = 18'h01000,
      ST_MX     = 18'h02000,
      ST_MY     = 18'h04000,
      ST_DSTART = 18'h08000,
      ST_DWAIT  = 18'h10000,
      ST_FIN    = 18'h20000
   } state_type;

   localparam int IDX_W = kvi_pkg::IDX_W;
   localparam int CNT_W = kvi_pkg::CNT_W;
   localparam int VAL_W = kvi_pkg::VAL_W;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [IDX_W-1:0]            seg_idx_ff, seg_idx_in;
   kvi_pkg::key_type            seg_s_ff, seg_s_in, seg_e_ff, seg_e_in;
   logic [CNT_W-1:0]            idx_ff, idx_in, jdx_ff, jdx_in;
   logic [1:0]                  kind_ff, kind_in;
   logic [kvi_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [VAL_W-1:0]            vx_ff, vx_in, vy_ff, vy_in;
   logic [VAL_W-1:0]            res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                        res_st_ff, res_st_in;
   logic signed [kvi_pkg::PROD_W-1:0] prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   logic                        neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]            out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                        out_st_ff, out_st_in;

   logic                        ram_we, ram_re;
   logic [IDX_W-1:0]            ram_waddr, ram_raddr;
   kvi_pkg::key_type            ram_wdata, ram_rdata;

   kvi_pkg::div_req_type        div_req;
   kvi_pkg::div_rsp_type        div_rsp;

   logic                        accept;
   logic                        fin_load;
   logic signed [kvi_pkg::NUM_W-1:0]  num;
   logic signed [kvi_pkg::NUM_W-1:0]  den;
   logic signed [kvi_pkg::DIFF_W-1:0] diff_x, diff_y;
   logic [kvi_pkg::PROD_W-1:0]  mag_x, mag_y;
   logic [kvi_pkg::SUM_W-1:0]   a_x, a_y, q_x, q_y, sum_x, sum_y;
   kvi_pkg::key_type            new_key;

   kvi_ram #(
      .WIDTH (kvi_pkg::KEY_W),
      .DEPTH (kvi_pkg::MAX_KEYS)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   kvi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign fin_load      = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   assign new_key.step  = step_ff;
   assign new_key.x     = vx_ff;
   assign new_key.y     = vy_ff;

   // interpolation terms
   assign num    = {1'b0, step_ff} - {1'b0, seg_s_ff.step};
   assign den    = {1'b0, seg_e_ff.step} - {1'b0, seg_s_ff.step};
   assign diff_x = {seg_e_ff.x[VAL_W-1], seg_e_ff.x} - {seg_s_ff.x[VAL_W-1], seg_s_ff.x};
   assign diff_y = {seg_e_ff.y[VAL_W-1], seg_e_ff.y} - {seg_s_ff.y[VAL_W-1], seg_s_ff.y};
   assign mag_x  = prod_x_ff[kvi_pkg::PROD_W-1] ? kvi_pkg::PROD_W'(-prod_x_ff) : prod_x_ff;
   assign mag_y  = prod_y_ff[kvi_pkg::PROD_W-1] ? kvi_pkg::PROD_W'(-prod_y_ff) : prod_y_ff;
   assign a_x    = {{(kvi_pkg::SUM_W-VAL_W){seg_s_ff.x[VAL_W-1]}}, seg_s_ff.x};
   assign a_y    = {{(kvi_pkg::SUM_W-VAL_W){seg_s_ff.y[VAL_W-1]}}, seg_s_ff.y};
   assign q_x    = {2'b00, div_rsp.qx};
   assign q_y    = {2'b00, div_rsp.qy};
   assign sum_x  = neg_x_ff ? a_x - q_x : a_x + q_x;
   assign sum_y  = neg_y_ff ? a_y - q_y : a_y + q_y;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      seg_idx_in = seg_idx_ff;
      seg_s_in   = seg_s_ff;
      seg_e_in   = seg_e_ff;
      idx_in     = idx_ff;
      jdx_in     = jdx_ff;
      kind_in    = kind_ff;
      step_in    = step_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      res_x_in   = res_x_ff;
      res_y_in   = res_y_ff;
      res_st_in  = res_st_ff;
      prod_x_in  = prod_x_ff;
      prod_y_in  = prod_y_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      ram_we     = 1'b0;
      ram_waddr  = idx_ff[IDX_W-1:0];
      ram_wdata  = new_key;
      ram_re     = 1'b0;
      ram_raddr  = idx_ff[IDX_W-1:0];
      div_req.start = 1'b0;
      div_req.nx = {mag_x, 1'b0} + kvi_pkg::DIVN_W'(den[kvi_pkg::STEP_W-1:0]);
      div_req.ny = {mag_y, 1'b0} + kvi_pkg::DIVN_W'(den[kvi_pkg::STEP_W-1:0]);
      div_req.d  = {den[kvi_pkg::STEP_W-1:0], 1'b0};

      unique case (state_ff)
         ST_INIT0: begin
            ram_we         = 1'b1;
            ram_waddr      = IDX_W'(0);
            ram_wdata.step = '0;
            ram_wdata.x    = kvi_pkg::VAL_ONE;
            ram_wdata.y    = kvi_pkg::VAL_ONE;
            state_in       = ST_INIT1;
         end
         ST_INIT1: begin
            ram_we         = 1'b1;
            ram_waddr      = IDX_W'(1);
            ram_wdata.step = kvi_pkg::Q_ONE;
            ram_wdata.x    = kvi_pkg::VAL_ONE;
            ram_wdata.y    = kvi_pkg::VAL_ONE;
            state_in       = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_ch.req_type;
               step_in   = req_ch.step;
               vx_in     = req_ch.val_x;
               vy_in     = req_ch.val_y;
               res_x_in  = '0;
               res_y_in  = '0;
               res_st_in = 1'b0;
               idx_in    = '0;
               unique case (req_ch.req_type)
                  kvi_pkg::REQ_SET: begin
                     state_in = (req_ch.step > kvi_pkg::Q_ONE) ? ST_FIN : ST_SK_RD;
                  end
                  kvi_pkg::REQ_START: begin
                     state_in = ST_ST0;
                  end
                  kvi_pkg::REQ_PROG: begin
                     idx_in   = CNT_W'(seg_idx_ff) + CNT_W'(1);
                     state_in = (req_ch.step > seg_e_ff.step) ? ST_PG_RD : ST_MX;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_SK_RD: begin
            if (idx_ff < cnt_ff) begin
               ram_re   = 1'b1;
               state_in = ST_SK_CHK;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SK_CHK: begin
            priority if (ram_rdata.step == step_ff) begin
               // replace in place
               ram_we   = 1'b1;
               state_in = ST_FIN;
            end else if (ram_rdata.step > step_ff) begin
               if (cnt_ff >= kvi_pkg::KEYS_FULL) begin
                  res_st_in = 1'b1;
                  state_in  = ST_FIN;
               end else begin
                  jdx_in   = cnt_ff;
                  state_in = ST_SH_RD;
               end
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_SK_RD;
            end
         end
         ST_SH_RD: begin
            if (jdx_ff > idx_ff) begin
               ram_re    = 1'b1;
               ram_raddr = IDX_W'(jdx_ff - CNT_W'(1));
               state_in  = ST_SH_WR;
            end else begin
               ram_we   = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_FIN;
            end
         end
         ST_SH_WR: begin
            // move one key up a slot
            ram_we    = 1'b1;
            ram_waddr = jdx_ff[IDX_W-1:0];
            ram_wdata = ram_rdata;
            jdx_in    = jdx_ff - CNT_W'(1);
            state_in  = ST_SH_RD;
         end
         ST_ST0: begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(0);
            state_in  = ST_ST1;
         end
         ST_ST1: begin
            seg_s_in  = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(1);
            state_in  = ST_ST2;
         end
         ST_ST2: begin
            seg_e_in   = ram_rdata;
            seg_idx_in = IDX_W'(1);
            state_in   = ST_FIN;
         end
         ST_PG_RD: begin
            if (idx_ff < cnt_ff) begin
               ram_re   = 1'b1;
               state_in = ST_PG_CHK;
            end else begin
               state_in = ST_MX;
            end
         end
         ST_PG_CHK: begin
            if (ram_rdata.step >= step_ff) begin
               seg_e_in   = ram_rdata;
               seg_idx_in = idx_ff[IDX_W-1:0];
               ram_re     = 1'b1;
               ram_raddr  = IDX_W'(idx_ff - CNT_W'(1));
               state_in   = ST_PG_PRV;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_PG_RD;
            end
         end
         ST_PG_PRV: begin
            seg_s_in = ram_rdata;
            state_in = ST_MX;
         end
         ST_MX: begin
            if (den <= 0) begin
               res_x_in = seg_s_ff.x;
               res_y_in = seg_s_ff.y;
               state_in = ST_FIN;
            end else begin
               prod_x_in = diff_x * num;
               state_in  = ST_MY;
            end
         end
         ST_MY: begin
            prod_y_in = diff_y * num;
            state_in  = ST_DSTART;
         end
         ST_DSTART: begin
            neg_x_in      = prod_x_ff[kvi_pkg::PROD_W-1];
            neg_y_in      = prod_y_ff[kvi_pkg::PROD_W-1];
            div_req.start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_rsp.done) begin
               res_x_in = kvi_pkg::sat_val(sum_x);
               res_y_in = kvi_pkg::sat_val(sum_y);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (fin_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: hold until taken
   always_comb begin
      rsp_valid_in = fin_load || (rsp_valid_ff && !rsp_ch.ready);
      out_x_in     = fin_load ? res_x_ff  : out_x_ff;
      out_y_in     = fin_load ? res_y_ff  : out_y_ff;
      out_st_in    = fin_load ? res_st_ff : out_st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT0;
         cnt_ff          <= CNT_W'(2);
         seg_idx_ff      <= IDX_W'(1);
         seg_s_ff.step   <= '0;
         seg_s_ff.x      <= kvi_pkg::VAL_ONE;
         seg_s_ff.y      <= kvi_pkg::VAL_ONE;
         seg_e_ff.step   <= kvi_pkg::Q_ONE;
         seg_e_ff.x      <= kvi_pkg::VAL_ONE;
         seg_e_ff.y      <= kvi_pkg::VAL_ONE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         seg_idx_ff      <= seg_idx_in;
         seg_s_ff        <= seg_s_in;
         seg_e_ff        <= seg_e_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      idx_ff    <= idx_in;
      jdx_ff    <= jdx_in;
      kind_ff   <= kind_in;
      step_ff   <= step_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_st_ff <= res_st_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      neg_x_ff  <= neg_x_in;
      neg_y_ff  <= neg_y_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_st_ff <= out_st_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.out_x  = out_x_ff;
   assign rsp_ch.out_y  = out_y_ff;
   assign rsp_ch.status = out_st_ff;

   // status flags only a dropped insert
   a_status_set_only: assert property (@(posedge clock) disable iff (reset)
      (fin_load && res_st_ff) |-> (kind_ff == kvi_pkg::REQ_SET))
      else $error("full-table status on a non set-key word");

   a_key_count_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= CNT_W'(2)) && (cnt_ff <= kvi_pkg::KEYS_FULL))
      else $error("key count out of range");

   a_segment_order: assert property (@(posedge clock) disable iff (reset)
      seg_e_ff.step > seg_s_ff.step)
      else $error("segment end step not above start step");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DWAIT))
      else $error("divider finished outside of wait state");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised without a finished item");
endmodule
`default_nettype wire

### dv/keyframe_vec2_interpolator_chk.sv
// Checker for the keyframe vec2 interpolator: watches both channels, predicts
// each response word from its own key table and compares. Depends on kvi_pkg and kvi_if.
`timescale 1ns / 100ps
module keyframe_vec2_interpolator_chk (
   input  wire logic  clock,
   input  wire logic  reset,
   kvi_req_if         req_ch,
   kvi_rsp_if         rsp_ch,
   output int         fail_count,
   output int         pending_count
);
   typedef struct {
      logic signed [kvi_pkg::VAL_W-1:0] x;
      logic signed [kvi_pkg::VAL_W-1:0] y;
      logic                             status;
   } interp_word_type;

   typedef struct {
      longint step;
      longint x;
      longint y;
   } frame_type;

   frame_type       keys[kvi_pkg::MAX_KEYS];
   int              n_keys;
   int              end_idx;
   frame_type       seg_a;
   frame_type       seg_b;
   interp_word_type expected_words[$];

   assign pending_count = expected_words.size();

   function automatic longint lerp_round(longint a, longint b, longint num, longint den);
      longint prod;
      longint mag;
      longint q;
      if (den <= 0) return a;
      prod = (b - a) * num;
      mag = (prod < 0) ? -prod : prod;
      q = (2 * mag + den) / (2 * den);
      return (prod < 0) ? a - q : a + q;
   endfunction

   function automatic logic [kvi_pkg::VAL_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[kvi_pkg::VAL_W-1:0];
   endfunction

   task automatic reset_table();
      for (int i = 0; i < kvi_pkg::MAX_KEYS; i++) keys[i] = '{0, 0, 0};
      keys[0] = '{0, 65536, 65536};
      keys[1] = '{65536, 65536, 65536};
      n_keys = 2;
      end_idx = 1;
      seg_a = keys[0];
      seg_b = keys[1];
   endtask

   task automatic predict_word(logic [1:0] kind, logic [kvi_pkg::STEP_W-1:0] s_in,
                               logic signed [kvi_pkg::VAL_W-1:0] vx,
                               logic signed [kvi_pkg::VAL_W-1:0] vy);
      interp_word_type w;
      longint s;
      longint num;
      longint den;
      w = '{0, 0, 0};
      s = s_in;
      if (kind == kvi_pkg::REQ_SET) begin
         if (s <= 65536) begin
            for (int i = 0; i < n_keys; i++) begin
               if (keys[i].step == s) begin
                  keys[i].x = vx;
                  keys[i].y = vy;
                  break;
               end
               if (keys[i].step > s) begin
                  if (n_keys >= kvi_pkg::MAX_KEYS) begin
                     w.status = 1'b1;
                     break;
                  end
                  for (int j = n_keys; j > i; j--) keys[j] = keys[j-1];
                  keys[i] = '{s, longint'(vx), longint'(vy)};
                  n_keys++;
                  break;
               end
            end
         end
      end else if (kind == kvi_pkg::REQ_START) begin
         seg_a = keys[0];
         seg_b = keys[1];
         end_idx = 1;
      end else if (kind == kvi_pkg::REQ_PROG) begin
         if (s > seg_b.step) begin
            for (int i = end_idx + 1; i < n_keys; i++) begin
               if (keys[i].step >= s) begin
                  seg_b = keys[i];
                  seg_a = keys[i-1];
                  end_idx = i;
                  break;
               end
            end
         end
         num = s - seg_a.step;
         den = seg_b.step - seg_a.step;
         w.x = clamp32(lerp_round(seg_a.x, seg_b.x, num, den));
         w.y = clamp32(lerp_round(seg_a.y, seg_b.y, num, den));
      end
      expected_words = {expected_words, w};
   endtask

   task automatic report_mismatch(string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      interp_word_type e;
      if (reset) begin
         reset_table();
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_word(req_ch.req_type, req_ch.step, req_ch.val_x, req_ch.val_y);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("response word with none expected");
            end else begin
               e = expected_words.pop_front();
               if (rsp_ch.out_x !== e.x)
                  report_mismatch($sformatf("out_x %h, want %h", rsp_ch.out_x, e.x));
               if (rsp_ch.out_y !== e.y)
                  report_mismatch($sformatf("out_y %h, want %h", rsp_ch.out_y, e.y));
               if (rsp_ch.status !== e.status)
                  report_mismatch($sformatf("status %b, want %b", rsp_ch.status, e.status));
            end
         end
      end
   end
endmodule

### dv/keyframe_vec2_interpolator_tb.sv
// Testbench top for the keyframe vec2 interpolator: drives request words and
// response stalls, and gives the verdict. Depends on kvi_pkg, kvi_if, the interpolator, checker.
`timescale 1ns / 100ps
module keyframe_vec2_interpolator_tb;
   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   int   n_sent;
   bit   calm;
   bit   timed_out;

   kvi_req_if req_ch ();
   kvi_rsp_if rsp_ch ();

   keyframe_vec2_interpolator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   keyframe_vec2_interpolator_chk i_chk (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // response stalls, none while calm
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= calm || ($urandom_range(99) >= 37);
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] kind, logic [kvi_pkg::STEP_W-1:0] s,
                            logic [kvi_pkg::VAL_W-1:0] vx, logic [kvi_pkg::VAL_W-1:0] vy);
      // drop valid for the idle cycles, then hold the word until taken
      while (!calm && $urandom_range(99) < 37) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.step     <= s;
      req_ch.val_x    <= vx;
      req_ch.val_y    <= vy;
      do @(posedge clock); while (!req_ch.ready);
      n_sent++;
   endtask

   function automatic logic [kvi_pkg::STEP_W-1:0] rand_step();
      case ($urandom_range(9))
         0: return kvi_pkg::STEP_W'($urandom_range(131071));
         1: return '0;
         2: return kvi_pkg::Q_ONE;
         3: return kvi_pkg::STEP_W'($urandom_range(65536, 65600));
         default: return kvi_pkg::STEP_W'($urandom_range(65536));
      endcase
   endfunction

   function automatic logic [kvi_pkg::VAL_W-1:0] rand_val();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return kvi_pkg::VAL_W'($urandom_range(400000)) - 200000;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_anim(int n_keys, bit full_range);
      logic [kvi_pkg::STEP_W-1:0] p;
      int inc;
      if ($urandom_range(3) == 0) send_word(kvi_pkg::REQ_START, 0, 0, 0);
      for (int i = 0; i < n_keys; i++)
         send_word(kvi_pkg::REQ_SET,
                   full_range ? rand_step() : kvi_pkg::STEP_W'($urandom_range(65536)),
                   rand_val(), rand_val());
      send_word(kvi_pkg::REQ_START, rand_step(), rand_val(), rand_val());
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(4) == 0) begin
            p = rand_step();
         end else begin
            inc = int'($urandom_range(12000));
            p = (int'(p) + inc > 131071) ? kvi_pkg::Q_ONE
                                         : kvi_pkg::STEP_W'(int'(p) + inc);
         end
         send_word(kvi_pkg::REQ_PROG, p, rand_val(), rand_val());
      end
   endtask

   initial begin
      reset           = 1'b1;
      calm            = 1'b0;
      timed_out       = 1'b0;
      n_sent          = 0;
      req_ch.valid    = 1'b0;
      req_ch.req_type = kvi_pkg::REQ_SET;
      req_ch.step     = '0;
      req_ch.val_x    = '0;
      req_ch.val_y    = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: default segment, extremes, reserved code, filling the table
      send_word(kvi_pkg::REQ_PROG, 0, 0, 0);
      send_word(kvi_pkg::REQ_PROG, 17'h1ffff, 0, 0);
      send_word(kvi_pkg::REQ_SET, kvi_pkg::Q_ONE, 32'h7fffffff, 32'h80000000);
      send_word(kvi_pkg::REQ_SET, 0, 32'h80000000, 32'h7fffffff);
      send_word(kvi_pkg::REQ_PROG, 32768, 0, 0);
      send_word(kvi_pkg::REQ_START, 0, 32'hffffffff, 32'hffffffff);
      send_word(kvi_pkg::REQ_PROG, 32768, 0, 0);
      send_word(kvi_pkg::REQ_PROG, 17'h1ffff, 0, 0);
      send_word(kvi_pkg::REQ_PROG, 0, 0, 0);
      send_word(kvi_pkg::REQ_SET, 17'h10001, 32'h5555aaaa, 32'haaaa5555);
      send_word(kvi_pkg::REQ_RSVD, 17'h1ffff, 32'hffffffff, 32'hffffffff);
      for (int i = 1; i <= 14; i++)
         send_word(kvi_pkg::REQ_SET, kvi_pkg::STEP_W'(i * 4096), rand_val(), rand_val());
      send_word(kvi_pkg::REQ_SET, 100, 1, 2);
      send_word(kvi_pkg::REQ_SET, 4096, 3, 4);
      send_word(kvi_pkg::REQ_START, 0, 0, 0);
      for (int i = 0; i < 6; i++)
         send_word(kvi_pkg::REQ_PROG, kvi_pkg::STEP_W'(i * 13000 + 1), 0, 0);

      while (n_sent < 1050) begin
         calm = (n_sent >= 300 && n_sent < 420);
         if ($urandom_range(9) == 0) begin
            send_word(2'($urandom_range(3)), rand_step(), rand_val(), rand_val());
         end else begin
            // now and then overwrite keys at fixed steps, which does not clear the table
            if ($urandom_range(5) == 0) begin
               reset_keys();
            end
            run_anim($urandom_range(1, 5), $urandom_range(3) == 0);
         end
      end
      req_ch.valid <= 1'b0;
      calm = 1'b1;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // overwrite keys at fixed steps so the table gets reused; it never shrinks
   task automatic reset_keys();
      for (int i = 0; i < 3; i++)
         send_word(kvi_pkg::REQ_SET, kvi_pkg::STEP_W'($urandom_range(16) * 4096),
                   rand_val(), rand_val());
   endtask
endmodule

### sim.f
hw/rtl/kvi_pkg.sv
hw/rtl/kvi_if.sv
hw/rtl/kvi_ram.sv
hw/rtl/kvi_div.sv
hw/rtl/keyframe_vec2_interpolator.sv
dv/keyframe_vec2_interpolator_chk.sv
dv/keyframe_vec2_interpolator_tb.sv
